// File: rtl/mts_pkg.sv
// Package for the min tracking stack.
// Holds the depth, widths, command and status codes, and the entry and shift types.
// No dependencies.
`timescale 1ns / 1ps

package mts_pkg;

	localparam int DEPTH  = 16;
	localparam int VAL_W  = 32;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int FILL_W = 5;
	localparam int CMD_W  = 2;
	localparam int STAT_W = 2;

	typedef logic [CMD_W-1:0]  cmd_t;
	typedef logic [STAT_W-1:0] status_t;
	typedef logic [CNT_W-1:0]  count_t;

	localparam cmd_t CMD_PUSH = 2'd0;
	localparam cmd_t CMD_POP  = 2'd1;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_OVERFLOW = 2'd1;
	localparam status_t ST_EMPTY    = 2'd2;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic signed [VAL_W-1:0] mval;
	} entry_t;

	typedef struct packed {
		logic push;
		logic pop;
	} shift_ctl_t;

endpackage

// File: rtl/mts_cell.sv
// One stack cell: holds one entry, loads from the cell above on push,
// from the cell below on pop. Depends on mts_pkg.
`timescale 1ns / 1ps

module mts_cell
	import mts_pkg::*;
(
	input  logic       clk,
	input  shift_ctl_t ctl,
	input  entry_t     from_up,
	input  entry_t     from_down,
	output entry_t     entry
);

	entry_t entry_q;

	always_ff @(posedge clk) begin
		priority if (ctl.push) begin
			entry_q <= from_up;
		end else if (ctl.pop) begin
			entry_q <= from_down;
		end else begin
			entry_q <= entry_q;
		end
	end

	assign entry = entry_q;

endmodule

// File: rtl/mts_ctrl.sv
// Stack control: request handshake, fill count, new entry and min update,
// result register. Depends on mts_pkg.
`timescale 1ns / 1ps

module mts_ctrl
	import mts_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  cmd_t                     cmd,
	input  logic signed [VAL_W-1:0]  push_value,
	input  entry_t                   top_entry,
	input  entry_t                   next_entry,
	output shift_ctl_t               ctl,
	output entry_t                   new_entry,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output logic signed [VAL_W-1:0]  top_value,
	output logic signed [VAL_W-1:0]  min_value,
	output count_t                   count,
	output status_t                  status,
	output logic                     is_empty
);

	count_t                  count_q;
	logic                    rsp_valid_q;
	logic signed [VAL_W-1:0] top_q;
	logic signed [VAL_W-1:0] min_q;
	count_t                  cnt_rsp_q;
	status_t                 status_q;
	logic                    empty_rsp_q;

	logic                    accept;
	logic                    full;
	logic                    empty;
	logic                    less;
	count_t                  count_nxt;
	status_t                 status_nxt;
	logic signed [VAL_W-1:0] top_nxt;
	logic signed [VAL_W-1:0] min_nxt;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign less      = (push_value < top_entry.mval);

	assign ctl.push  = accept && (cmd == CMD_PUSH) && !full;
	assign ctl.pop   = accept && (cmd == CMD_POP) && !empty;

	assign new_entry.value = push_value;
	assign new_entry.mval  = (!empty && !less) ? top_entry.mval : push_value;

	always_comb begin
		count_nxt  = count_q;
		status_nxt = ST_OK;
		top_nxt    = empty ? '0 : top_entry.value;
		min_nxt    = empty ? '0 : top_entry.mval;
		priority if (ctl.push) begin
			count_nxt = count_q + 1'b1;
			top_nxt   = new_entry.value;
			min_nxt   = new_entry.mval;
		end else if (ctl.pop) begin
			count_nxt = count_q - 1'b1;
			if (count_q == CNT_W'(1)) begin
				top_nxt = '0;
				min_nxt = '0;
			end else begin
				top_nxt = next_entry.value;
				min_nxt = next_entry.mval;
			end
		end else if (cmd == CMD_PUSH) begin
			status_nxt = ST_OVERFLOW;
		end else if (cmd == CMD_POP) begin
			status_nxt = ST_EMPTY;
		end else begin
			status_nxt = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			top_q       <= top_nxt;
			min_q       <= min_nxt;
			cnt_rsp_q   <= count_nxt;
			status_q    <= status_nxt;
			empty_rsp_q <= (count_nxt == '0);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign top_value = top_q;
	assign min_value = min_q;
	assign count     = cnt_rsp_q;
	assign status    = status_q;
	assign is_empty  = empty_rsp_q;

endmodule

// File: rtl/min_tracking_stack.sv
// Min tracking stack: LIFO of signed values with running minimum per entry.
// Responses are registered, valid in the next cycle; one request per cycle
// while the response side does not stall. The stack is a row of shifting cells,
// top entry in the first cell. Reset clears the fill count and response valid;
// cell contents are not cleared. Depends on mts_pkg, mts_cell, mts_ctrl.
`timescale 1ns / 1ps

module min_tracking_stack
	import mts_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  logic [CMD_W-1:0]         cmd,
	input  logic signed [VAL_W-1:0]  push_value,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output logic signed [VAL_W-1:0]  top_value,
	output logic signed [VAL_W-1:0]  min_value,
	output logic [FILL_W-1:0]        fill_count,
	output logic [STAT_W-1:0]        status,
	output logic                     is_empty
);

	shift_ctl_t ctl;
	entry_t     new_entry;
	entry_t     cells [DEPTH];
	entry_t     next_entry;
	count_t     count;

	assign next_entry = cells[1];

	mts_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.cmd        (cmd),
		.push_value (push_value),
		.top_entry  (cells[0]),
		.next_entry (next_entry),
		.ctl        (ctl),
		.new_entry  (new_entry),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.top_value  (top_value),
		.min_value  (min_value),
		.count      (count),
		.status     (status),
		.is_empty   (is_empty)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t up;
		entry_t down;
		if (i == 0) begin : g_first
			assign up = new_entry;
		end else begin : g_mid
			assign up = cells[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign down = '0;
		end else begin : g_inner
			assign down = cells[i+1];
		end
		mts_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.from_up   (up),
			.from_down (down),
			.entry     (cells[i])
		);
	end

	assign fill_count = FILL_W'(count);

endmodule

// File: rtl/mts_checker.sv
// Port-level checks for min_tracking_stack, attached by bind.
// Depends on mts_pkg.
`timescale 1ns / 1ps

module mts_checker
	import mts_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     rsp_valid,
	input logic                     rsp_stall,
	input logic signed [VAL_W-1:0]  top_value,
	input logic signed [VAL_W-1:0]  min_value,
	input logic [FILL_W-1:0]        fill_count,
	input logic [STAT_W-1:0]        status,
	input logic                     is_empty
);

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (is_empty == (fill_count == '0)))
		else $error("is_empty disagrees with fill_count");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && is_empty |-> (top_value == '0) && (min_value == '0))
		else $error("empty stack reports nonzero top or min");

	a_min_le_top: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !is_empty |-> (min_value <= top_value))
		else $error("min exceeds top");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_OVERFLOW) |-> (fill_count == FILL_W'(DEPTH)))
		else $error("overflow reported on a stack that is not full");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(top_value) && $stable(min_value)
			&& $stable(fill_count) && $stable(status))
		else $error("stalled response changed");

endmodule

bind min_tracking_stack mts_checker u_mts_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp_valid),
	.rsp_stall  (rsp_stall),
	.top_value  (top_value),
	.min_value  (min_value),
	.fill_count (fill_count),
	.status     (status),
	.is_empty   (is_empty)
);

// File: tb/sv/tb_min_tracking_stack.sv
// Testbench for min_tracking_stack: directed and random push/pop/read/spare requests,
// checked against an in-bench stack model with per-entry running minimum.
// Depends on mts_pkg and min_tracking_stack.
`timescale 1ns / 1ps

module tb_min_tracking_stack;
	import mts_pkg::*;

	localparam cmd_t CMD_READ  = 2'd2;
	localparam cmd_t CMD_SPARE = 2'd3;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam int QUIET_LIMIT = 2000;

	typedef struct packed {
		logic signed [VAL_W-1:0] top;
		logic signed [VAL_W-1:0] mval;
		logic [FILL_W-1:0]       fill;
		status_t                 st;
		logic                    empty;
	} stack_view_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    req_valid;
	logic                    req_stall;
	cmd_t                    cmd;
	logic signed [VAL_W-1:0] push_value;
	logic                    rsp_valid;
	logic                    rsp_stall;
	logic signed [VAL_W-1:0] top_value;
	logic signed [VAL_W-1:0] min_value;
	logic [FILL_W-1:0]       fill_count;
	status_t                 status;
	logic                    is_empty;

	logic signed [VAL_W-1:0] shadow_val [DEPTH];
	logic signed [VAL_W-1:0] shadow_min [DEPTH];
	int                      shadow_count;
	stack_view_t             pending_views [$];

	int  mismatches;
	int  quiet_cycles;
	int  rsp_hold_cycles;
	int  rsp_burst_left;
	bit  gaps_on;

	min_tracking_stack DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.cmd        (cmd),
		.push_value (push_value),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.top_value  (top_value),
		.min_value  (min_value),
		.fill_count (fill_count),
		.status     (status),
		.is_empty   (is_empty)
	);

	always #5 clk = ~clk;

	function automatic stack_view_t apply_request(cmd_t c, logic signed [VAL_W-1:0] v);
		stack_view_t             r;
		logic signed [VAL_W-1:0] m;
		r    = '0;
		r.st = ST_OK;
		if (c == CMD_PUSH) begin
			if (shadow_count >= DEPTH) begin
				r.st = ST_OVERFLOW;
			end else begin
				m = v;
				if (shadow_count > 0 && shadow_min[shadow_count-1] < v)
					m = shadow_min[shadow_count-1];
				shadow_val[shadow_count] = v;
				shadow_min[shadow_count] = m;
				shadow_count++;
			end
		end else if (c == CMD_POP) begin
			if (shadow_count == 0)
				r.st = ST_EMPTY;
			else
				shadow_count--;
		end
		if (shadow_count > 0) begin
			r.top  = shadow_val[shadow_count-1];
			r.mval = shadow_min[shadow_count-1];
		end
		r.fill  = FILL_W'(shadow_count);
		r.empty = (shadow_count == 0);
		return r;
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_value();
		int roll;
		roll = $urandom_range(0, 7);
		case (roll)
			0: begin
				return VAL_MAX;
			end
			1: begin
				return VAL_MIN;
			end
			2: begin
				return VAL_W'($signed($urandom_range(0, 2)) - 1);
			end
			3, 4: begin
				return VAL_W'($signed($urandom_range(0, 16)) - 8);
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	task automatic log_mismatch(string what, stack_view_t exp, stack_view_t act);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t mismatch: %s", $time, what);
			$display("  expected top=%0d min=%0d fill=%0d status=%0d empty=%0d",
				exp.top, exp.mval, exp.fill, exp.st, exp.empty);
			$display("  actual   top=%0d min=%0d fill=%0d status=%0d empty=%0d",
				act.top, act.mval, act.fill, act.st, act.empty);
		end
	endtask

	// response checker
	always @(posedge clk) begin
		stack_view_t act;
		stack_view_t exp;
		if (arst_n && rsp_valid && !rsp_stall) begin
			act = '{top_value, min_value, fill_count, status, is_empty};
			if (pending_views.size() == 0) begin
				log_mismatch("response with no request pending", '0, act);
			end else begin
				exp = pending_views.pop_front();
				if (act.top !== exp.top || act.mval !== exp.mval || act.fill !== exp.fill
						|| act.st !== exp.st || act.empty !== exp.empty)
					log_mismatch("response fields differ", exp, act);
			end
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
				$display("FAIL");
				$finish;
			end
		end
	end

	// response side stall: long hold-off on request, else random bursts
	always @(negedge clk) begin
		if (rsp_hold_cycles > 0) begin
			rsp_hold_cycles--;
			rsp_stall <= 1'b1;
		end else if (rsp_burst_left > 0) begin
			rsp_burst_left--;
			rsp_stall <= 1'b1;
		end else if (gaps_on && $urandom_range(0, 9) == 0) begin
			rsp_burst_left = $urandom_range(1, 12) - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	task automatic send_request(cmd_t c, logic signed [VAL_W-1:0] v);
		int gap;
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 12);
			req_valid  <= 1'b0;
			cmd        <= cmd_t'($urandom_range(0, 3));
			push_value <= $urandom;
			repeat (gap) @(negedge clk);
		end
		req_valid  <= 1'b1;
		cmd        <= c;
		push_value <= v;
		do @(posedge clk); while (req_stall);
		pending_views.push_back(apply_request(c, v));
	endtask

	task automatic drain_responses();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_views.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic test_empty_stack();
		send_request(CMD_READ, 32'sd5);
		send_request(CMD_POP, 32'sd0);
		send_request(CMD_SPARE, VAL_MIN);
	endtask

	// fill to the top with extremes and tied minimums, overflow, then unwind a little
	task automatic test_fill_and_overflow();
		logic signed [VAL_W-1:0] seq [DEPTH];
		seq = '{32'sd10, VAL_MAX, 32'sd10, 32'sd3, -32'sd1, 32'sd0, VAL_MIN, VAL_MAX,
			VAL_MIN, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sd1, -32'sd2, 32'sd0,
			32'sh0F0F_0F0F, 32'shF0F0_F0F0};
		foreach (seq[i])
			send_request(CMD_PUSH, seq[i]);
		send_request(CMD_PUSH, VAL_MIN);
		send_request(CMD_SPARE, 32'sd0);
		repeat (4)
			send_request(CMD_POP, VAL_MAX);
	endtask

	task automatic test_backpressure();
		rsp_hold_cycles = 80;
		repeat (24)
			send_request(($urandom_range(0, 2) != 0) ? CMD_PUSH : CMD_POP, pick_value());
	endtask

	// biased walks so the stack keeps reaching both full and empty
	task automatic test_random_walk(int n_items);
		int   bias;
		int   roll;
		cmd_t c;
		bias = 0;
		for (int i = 0; i < n_items; i++) begin
			if (i % 40 == 0)
				bias = $urandom_range(0, 2);
			roll = $urandom_range(0, 99);
			if (roll < (bias == 0 ? 70 : bias == 1 ? 25 : 45))
				c = CMD_PUSH;
			else if (roll < (bias == 1 ? 82 : 86))
				c = CMD_POP;
			else if (roll < 97)
				c = CMD_READ;
			else
				c = CMD_SPARE;
			send_request(c, pick_value());
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		req_valid       = 1'b0;
		cmd             = CMD_READ;
		push_value      = '0;
		rsp_stall       = 1'b0;
		rsp_hold_cycles = 0;
		rsp_burst_left  = 0;
		gaps_on         = 1'b0;
		mismatches      = 0;
		quiet_cycles    = 0;
		shadow_count    = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_stack();
		test_fill_and_overflow();
		gaps_on = 1'b1;
		test_backpressure();
		test_random_walk(1000);
		gaps_on = 1'b0;
		test_random_walk(100);
		drain_responses();

		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: filelist.f
rtl/mts_pkg.sv
rtl/mts_cell.sv
rtl/mts_ctrl.sv
rtl/min_tracking_stack.sv
rtl/mts_checker.sv
tb/sv/tb_min_tracking_stack.sv
